[rtl/image_two_by_two_reducer_macros.svh]
// ----------------------------------------------------------------------------
// Reducer assertion macros
// Shared concurrent assertion forms used by the reducer modules.
// ----------------------------------------------------------------------------
`ifndef IMAGE_TWO_BY_TWO_REDUCER_MACROS_SVH
`define IMAGE_TWO_BY_TWO_REDUCER_MACROS_SVH

// Same-cycle implication, disabled during reset
`define IRED_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define IRED_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/ired_pkg.sv]
// ----------------------------------------------------------------------------
// Reducer package
// Types and constants shared by the 2x2 reducer controller and datapath.
// ----------------------------------------------------------------------------
package ired_pkg;

  // Sample and accumulator widths
  localparam int SAMPLE_BITS = 16;
  localparam int ENTRY_W     = SAMPLE_BITS + 1;
  localparam int SUM_W       = SAMPLE_BITS + 2;
  localparam int CNT_W       = 3;

  // Divide by three: (sum * RECIP3) >> RECIP_SHIFT is exact for sum < 3 * 2^16
  localparam int RECIP_SHIFT = 19;
  localparam int RECIP_W     = 18;
  localparam int PROD_W      = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP3 = 18'd174763;

  // Combine modes
  localparam logic [2:0] MODE_FIRST = 3'd0;
  localparam logic [2:0] MODE_MEAN  = 3'd1;
  localparam logic [2:0] MODE_MEANP = 3'd2;
  localparam logic [2:0] MODE_MIN   = 3'd3;
  localparam logic [2:0] MODE_MAX   = 3'd4;

  // Configuration register indexes
  localparam logic [1:0] CFG_MODE     = 2'd0;
  localparam logic [1:0] CFG_WIDTH    = 2'd1;
  localparam logic [1:0] CFG_CHANNELS = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;   // input word accepted this cycle
    logic stats_en;  // register count, sum, min, max
    logic scale_en;  // register divide-by-three product
    logic load_out;  // load the output register
  } ired_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic need_result;  // current input word closes a 2x2 block
  } ired_stat_t;

endpackage

[rtl/ired_ctrl.sv]
// ----------------------------------------------------------------------------
// Reducer controller
// Sequences capture, statistics, scaling and output load for each block.
// ----------------------------------------------------------------------------
`include "image_two_by_two_reducer_macros.svh"

module ired_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  ired_pkg::ired_stat_t stat,
  output ired_pkg::ired_cmd_t  cmd
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_STATS = 4'b0010,
    ST_SCALE = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_t;

  state_t state, state_next;
  logic   out_valid_next;
  logic   out_free;

  // Output register can take a new word
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != ST_IDLE);

  // Commands
  always_comb begin
    cmd          = '0;
    cmd.capture  = in_valid && (state == ST_IDLE);
    cmd.stats_en = (state == ST_STATS);
    cmd.scale_en = (state == ST_SCALE);
    cmd.load_out = (state == ST_EMIT) && out_free;
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cmd.capture && stat.need_result) state_next = ST_STATS;
      end
      ST_STATS: state_next = ST_SCALE;
      ST_SCALE: state_next = ST_EMIT;
      ST_EMIT: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Output valid flag
  always_comb begin
    out_valid_next = out_valid;
    if (cmd.load_out) out_valid_next = 1'b1;
    else if (out_valid && !out_stall) out_valid_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // Assertions
  `IRED_ASSERT_IMP(a_load_free, clk, rst, cmd.load_out, !out_valid || !out_stall, "load over a pending word")
  `IRED_ASSERT_NXT(a_block_starts, clk, rst, cmd.capture && stat.need_result, state == ST_STATS, "block capture did not start sequence")
  `IRED_ASSERT_NXT(a_stats_then_scale, clk, rst, state == ST_STATS, state == ST_SCALE && in_stall, "stats stage not followed by scale")
  `IRED_ASSERT_NXT(a_load_sets_valid, clk, rst, cmd.load_out, out_valid && !in_stall, "output load lost")

endmodule

[rtl/ired_datapath.sv]
// ----------------------------------------------------------------------------
// Reducer datapath
// Raster position, even-row line store, odd-row hold and block combiner.
// ----------------------------------------------------------------------------
module ired_datapath #(
  parameter int MAX_WIDTH    = 4096,
  parameter int MAX_CHANNELS = 4
) (
  input  logic                                clk,
  input  logic                                rst,
  input  ired_pkg::ired_cmd_t                 cmd,
  output ired_pkg::ired_stat_t                stat,
  input  logic [2:0]                          combine_mode,
  input  logic [12:0]                         image_width,
  input  logic [2:0]                          channel_count,
  input  logic [ired_pkg::SAMPLE_BITS-1:0]    sample_value,
  input  logic                                sample_present,
  input  logic                                frame_start,
  output logic [ired_pkg::SAMPLE_BITS-1:0]    result_value,
  output logic                                result_present,
  output logic                                row_end
);

  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int CHB    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int AW     = CW + CHB;
  localparam int DEPTH  = 1 << AW;
  localparam int HDEPTH = 1 << CHB;
  localparam int SB     = ired_pkg::SAMPLE_BITS;
  localparam int EW     = ired_pkg::ENTRY_W;

  logic [CW-1:0]  col, col_next, cur_col;
  logic [CHB-1:0] ch, ch_next, cur_ch;
  logic           odd, odd_next, cur_odd;
  logic [31:0]    w_lim, cc_lim, col_inc, ch_inc, last_odd;
  logic [EW-1:0]  entry;
  logic [AW-1:0]  addr_cur, addr_left;
  logic           row_end_calc;

  logic [EW-1:0]  store [DEPTH];
  logic [EW-1:0]  hold  [HDEPTH];
  logic [EW-1:0]  rd_tl, rd_tr, e2_q, e3_q;
  logic           re_q;

  logic [EW-1:0]                   blk [4];
  logic [ired_pkg::SUM_W-1:0]      sum_c, sum_q;
  logic [ired_pkg::CNT_W-1:0]      cnt_c, cnt_q;
  logic [SB-1:0]                   lo_c, hi_c, lo_q, hi_q;
  logic [SB-1:0]                   first_v_q;
  logic                            first_p_q;
  logic [ired_pkg::PROD_W-1:0]     prod_q;
  logic [SB-1:0]                   fin_v;
  logic                            fin_p;

  // Effective width and channel count, clamped
  always_comb begin
    if (image_width < 13'd2) w_lim = 32'd2;
    else if ({19'b0, image_width} > 32'(MAX_WIDTH)) w_lim = 32'(MAX_WIDTH);
    else w_lim = {19'b0, image_width};
    if (channel_count == 3'd0) cc_lim = 32'd1;
    else if ({29'b0, channel_count} > 32'(MAX_CHANNELS)) cc_lim = 32'(MAX_CHANNELS);
    else cc_lim = {29'b0, channel_count};
  end

  // Position of the current word, frame start restarts at the origin
  assign cur_col   = frame_start ? '0 : col;
  assign cur_ch    = frame_start ? '0 : ch;
  assign cur_odd   = frame_start ? 1'b0 : odd;
  assign entry     = {sample_present, sample_value};
  assign addr_cur  = {cur_col, cur_ch};
  assign addr_left = {cur_col - CW'(1), cur_ch};
  assign stat.need_result = cur_odd && cur_col[0];

  // Last odd column and end-of-row flag
  assign last_odd     = w_lim[0] ? (w_lim - 32'd2) : (w_lim - 32'd1);
  assign row_end_calc = ((32'(cur_col)) == last_odd) && ((32'(cur_ch) + 32'd1) == cc_lim);

  // Position advance
  always_comb begin
    col_inc  = 32'(cur_col) + 32'd1;
    ch_inc   = 32'(cur_ch) + 32'd1;
    col_next = cur_col;
    ch_next  = cur_ch;
    odd_next = cur_odd;
    if (ch_inc >= cc_lim) begin
      ch_next = '0;
      if (col_inc >= w_lim) begin
        col_next = '0;
        odd_next = !cur_odd;
      end else begin
        col_next = col_inc[CW-1:0];
      end
    end else begin
      ch_next = ch_inc[CHB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      ch  <= '0;
      odd <= 1'b0;
    end else if (cmd.capture) begin
      col <= col_next;
      ch  <= ch_next;
      odd <= odd_next;
    end
  end

  // Even-row line store: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (cmd.capture && !cur_odd) store[addr_cur] <= entry;
    if (cmd.capture) begin
      rd_tr <= store[addr_cur];
      rd_tl <= store[addr_left];
    end
  end

  // Odd-row left hold and block capture
  always_ff @(posedge clk) begin
    if (cmd.capture && cur_odd && !cur_col[0]) hold[cur_ch] <= entry;
    if (cmd.capture && stat.need_result) begin
      e2_q <= hold[cur_ch];
      e3_q <= entry;
      re_q <= row_end_calc;
    end
  end

  // Block statistics over present samples
  assign blk[0] = rd_tl;
  assign blk[1] = rd_tr;
  assign blk[2] = e2_q;
  assign blk[3] = e3_q;

  always_comb begin
    sum_c = '0;
    cnt_c = '0;
    lo_c  = '1;
    hi_c  = '0;
    for (int i = 0; i < 4; i++) begin
      if (blk[i][EW-1]) begin
        sum_c = sum_c + ired_pkg::SUM_W'(blk[i][SB-1:0]);
        cnt_c = cnt_c + ired_pkg::CNT_W'(1);
        if (blk[i][SB-1:0] < lo_c) lo_c = blk[i][SB-1:0];
        if (blk[i][SB-1:0] > hi_c) hi_c = blk[i][SB-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.stats_en) begin
      sum_q     <= sum_c;
      cnt_q     <= cnt_c;
      lo_q      <= lo_c;
      hi_q      <= hi_c;
      first_v_q <= rd_tl[SB-1:0];
      first_p_q <= rd_tl[EW-1];
    end
    if (cmd.scale_en) begin
      prod_q <= ired_pkg::PROD_W'(sum_q) * ired_pkg::PROD_W'(ired_pkg::RECIP3);
    end
  end

  // Mode select
  always_comb begin
    fin_v = '0;
    fin_p = 1'b0;
    case (combine_mode)
      ired_pkg::MODE_FIRST: begin
        fin_p = first_p_q;
        fin_v = first_p_q ? first_v_q : '0;
      end
      ired_pkg::MODE_MEAN: begin
        if (cnt_q == 3'd4) begin
          fin_p = 1'b1;
          fin_v = sum_q[SB+1:2];
        end
      end
      ired_pkg::MODE_MEANP: begin
        fin_p = (cnt_q != 3'd0);
        case (cnt_q)
          3'd1:    fin_v = sum_q[SB-1:0];
          3'd2:    fin_v = sum_q[SB:1];
          3'd3:    fin_v = prod_q[ired_pkg::RECIP_SHIFT+SB-1:ired_pkg::RECIP_SHIFT];
          3'd4:    fin_v = sum_q[SB+1:2];
          default: fin_v = '0;
        endcase
      end
      ired_pkg::MODE_MIN: begin
        if (cnt_q != 3'd0) begin
          fin_p = 1'b1;
          fin_v = lo_q;
        end
      end
      ired_pkg::MODE_MAX: begin
        if (cnt_q != 3'd0) begin
          fin_p = 1'b1;
          fin_v = hi_q;
        end
      end
      default: begin
        fin_p = 1'b0;
        fin_v = '0;
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      result_value   <= fin_v;
      result_present <= fin_p;
      row_end        <= re_q;
    end
  end

endmodule

[rtl/image_two_by_two_reducer.sv]
// ----------------------------------------------------------------------------
// Image 2x2 reducer
// Reduces raster image samples over 2x2 blocks per channel (first, mean,
// mean of present, minimum, maximum), one result word per block channel.
// ----------------------------------------------------------------------------
//  channel | signals                                        | handshake
//  --------+------------------------------------------------+---------------
//  input   | sample_value, sample_present, frame_start      | in_valid/in_stall
//  output  | result_value, result_present, row_end          | out_valid/out_stall
//  config  | cfg_index, cfg_data                            | cfg_valid/cfg_ready
//
//  A word that closes no block (even rows, left column of a pair) needs only the capture step.
//  A word that closes a block runs through capture with line store read,
//  statistics, divide-by-three multiply and output load; a held output adds waits.
//  The output register lets the next word enter while a result waits.
//  Reset clears position and control; the line store needs no clearing pass.
//  cfg_ready is always high.
// ----------------------------------------------------------------------------
module image_two_by_two_reducer #(
  parameter int MAX_WIDTH    = 4096,
  parameter int MAX_CHANNELS = 4
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [ired_pkg::SAMPLE_BITS-1:0] sample_value,
  input  logic                             sample_present,
  input  logic                             frame_start,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [ired_pkg::SAMPLE_BITS-1:0] result_value,
  output logic                             result_present,
  output logic                             row_end,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [1:0]                       cfg_index,
  input  logic [12:0]                      cfg_data
);

  logic [2:0]           combine_mode;
  logic [12:0]          image_width;
  logic [2:0]           channel_count;
  ired_pkg::ired_cmd_t  cmd;
  ired_pkg::ired_stat_t stat;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      combine_mode  <= ired_pkg::MODE_MEAN;
      image_width   <= 13'd2;
      channel_count <= 3'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ired_pkg::CFG_MODE:     combine_mode  <= cfg_data[2:0];
        ired_pkg::CFG_WIDTH:    image_width   <= cfg_data;
        ired_pkg::CFG_CHANNELS: channel_count <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  ired_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  ired_datapath #(
    .MAX_WIDTH    (MAX_WIDTH),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .combine_mode   (combine_mode),
    .image_width    (image_width),
    .channel_count  (channel_count),
    .sample_value   (sample_value),
    .sample_present (sample_present),
    .frame_start    (frame_start),
    .result_value   (result_value),
    .result_present (result_present),
    .row_end        (row_end)
  );

endmodule

[tb/image_two_by_two_reducer_checker.sv]
// ----------------------------------------------------------------------------
// 2x2 reducer checker
// Watches the input, output and register channels of the reducer, keeps its
// own model of line store, left-sample hold and raster position, and compares
// every accepted result word field by field with the oldest expected word.
// ----------------------------------------------------------------------------
module image_two_by_two_reducer_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [15:0] sample_value,
  input  logic        sample_present,
  input  logic        frame_start,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [15:0] result_value,
  input  logic        result_present,
  input  logic        row_end,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data,
  output int          mismatch_count,
  output int          blocks_pending,
  output int          results_checked
);

  localparam int unsigned MAX_W      = 4096;
  localparam int unsigned MAX_CH     = 4;
  localparam int unsigned LINE_DEPTH = MAX_W * MAX_CH;
  localparam int          REPORT_MAX = 10;

  typedef struct packed {
    logic [15:0] value;
    logic        present;
    logic        row_end;
  } block_word_t;

  // Register copies
  logic [2:0]  mode_reg;
  logic [12:0] width_reg;
  logic [2:0]  chans_reg;

  // Sample stores: {present, value}
  logic [16:0] line_store [LINE_DEPTH];
  logic [16:0] left_hold [MAX_CH];

  // Raster position
  int unsigned col_pos;
  int unsigned chan_pos;
  logic        odd_row;

  block_word_t expected_blocks [$];

  function automatic int unsigned active_width(input logic [12:0] w);
    if (w < 2) return 2;
    if (w > MAX_W) return MAX_W;
    return 32'(w);
  endfunction

  function automatic int unsigned active_chans(input logic [2:0] c);
    if (c < 1) return 1;
    if (c > MAX_CH) return MAX_CH;
    return 32'(c);
  endfunction

  // Combine one block channel; samples in order TL, TR, BL, BR
  function automatic block_word_t reduce_block(input logic [2:0] mode,
                                               input logic [16:0] tl,
                                               input logic [16:0] tr,
                                               input logic [16:0] bl,
                                               input logic [16:0] br);
    logic [16:0] quad [4];
    logic [17:0] sum;
    int unsigned cnt;
    logic [15:0] lo;
    logic [15:0] hi;
    block_word_t r;
    quad[0] = tl;
    quad[1] = tr;
    quad[2] = bl;
    quad[3] = br;
    sum = '0;
    cnt = 0;
    lo = 16'hFFFF;
    hi = 16'h0000;
    r = '0;
    for (int i = 0; i < 4; i++) begin
      if (quad[i][16]) begin
        sum = sum + 18'(quad[i][15:0]);
        cnt++;
        if (quad[i][15:0] < lo) lo = quad[i][15:0];
        if (quad[i][15:0] > hi) hi = quad[i][15:0];
      end
    end
    case (mode)
      ired_pkg::MODE_FIRST: begin
        if (tl[16]) begin
          r.present = 1'b1;
          r.value   = tl[15:0];
        end
      end
      ired_pkg::MODE_MEAN: begin
        if (cnt == 4) begin
          r.present = 1'b1;
          r.value   = sum[17:2];
        end
      end
      ired_pkg::MODE_MEANP: begin
        if (cnt != 0) begin
          r.present = 1'b1;
          r.value   = 16'(sum / cnt);
        end
      end
      ired_pkg::MODE_MIN: begin
        if (cnt != 0) begin
          r.present = 1'b1;
          r.value   = lo;
        end
      end
      ired_pkg::MODE_MAX: begin
        if (cnt != 0) begin
          r.present = 1'b1;
          r.value   = hi;
        end
      end
      default: ;  // undefined modes give an absent zero
    endcase
    return r;
  endfunction

  // Advance the model by one accepted input word
  task automatic take_sample(input logic [15:0] v, input logic p, input logic fs);
    int unsigned w;
    int unsigned cc;
    int unsigned col;
    int unsigned ch;
    int unsigned idx;
    int unsigned last_odd;
    logic [16:0] entry;
    block_word_t r;
    w = active_width(width_reg);
    cc = active_chans(chans_reg);
    entry = {p, v};
    if (fs) begin
      col_pos  = 0;
      chan_pos = 0;
      odd_row  = 1'b0;
    end
    col = col_pos % MAX_W;
    ch  = chan_pos % MAX_CH;
    idx = (col * MAX_CH + ch) % LINE_DEPTH;

    if (!odd_row) begin
      line_store[idx] = entry;
    end else if (col % 2 == 0) begin
      left_hold[ch] = entry;
    end else begin
      last_odd = (w % 2 == 1) ? w - 2 : w - 1;
      r = reduce_block(mode_reg, line_store[(idx + LINE_DEPTH - MAX_CH) % LINE_DEPTH],
                       line_store[idx], left_hold[ch], entry);
      r.row_end = (col == last_odd) && (ch + 1 == cc);
      expected_blocks.push_back(r);
    end

    // Position wraps at the current bounds, even if it is already past them
    if (chan_pos + 1 >= cc) begin
      chan_pos = 0;
      if (col_pos + 1 >= w) begin
        col_pos = 0;
        odd_row = ~odd_row;
      end else begin
        col_pos = (col_pos + 1) & 32'hFFF;
      end
    end else begin
      chan_pos = (chan_pos + 1) & 32'h3;
    end
  endtask

  // Compare one accepted result word with the oldest expected one
  task automatic check_result();
    block_word_t got;
    block_word_t want;
    got = {result_value, result_present, row_end};
    results_checked++;
    if (expected_blocks.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_MAX)
        $display("ERROR: unexpected result word value %h present %b row_end %b",
                 got.value, got.present, got.row_end);
    end else begin
      want = expected_blocks.pop_front();
      if (got.value !== want.value || got.present !== want.present ||
          got.row_end !== want.row_end) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
          $display("ERROR: result %0d: value exp %h got %h, present exp %b got %b, %s",
                   results_checked, want.value, got.value, want.present, got.present,
                   $sformatf("row_end exp %b got %b", want.row_end, got.row_end));
      end
    end
  endtask

  // Output is checked before the input of the same edge is predicted
  always @(posedge clk) begin
    if (rst) begin
      mode_reg  = ired_pkg::MODE_MEAN;
      width_reg = 13'd2;
      chans_reg = 3'd1;
      col_pos   = 0;
      chan_pos  = 0;
      odd_row   = 1'b0;
      expected_blocks.delete();
      mismatch_count  = 0;
      results_checked = 0;
    end else begin
      if (out_valid && !out_stall) check_result();
      if (in_valid && !in_stall) take_sample(sample_value, sample_present, frame_start);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          ired_pkg::CFG_MODE:     mode_reg  = cfg_data[2:0];
          ired_pkg::CFG_WIDTH:    width_reg = cfg_data;
          ired_pkg::CFG_CHANNELS: chans_reg = cfg_data[2:0];
          default: ;  // no register at this index
        endcase
      end
    end
    blocks_pending = expected_blocks.size();
  end

endmodule

[tb/tb_image_two_by_two_reducer.sv]
// ----------------------------------------------------------------------------
// 2x2 reducer testbench
// Drives raster frames with missing samples through the reducer under many
// register settings (all modes, clamped and odd widths, 1 to 4 channels and
// out-of-range counts), with random gaps and stalls on both channels, a long
// output hold-off and a width change inside a frame. The checker predicts.
// ----------------------------------------------------------------------------
module tb_image_two_by_two_reducer;

  localparam int          WATCHDOG_LIMIT = 2000;
  localparam int          HOLDOFF_CYCLES = 250;
  localparam int          SETTLE_CYCLES  = 8;
  localparam int          RANDOM_WORDS   = 1020;
  localparam int          CLAMP_WORDS    = 64;
  localparam int          HOLDOFF_PHASE  = 1;
  localparam logic [2:0]  MODE_UNDEF     = 3'd7;
  localparam logic [1:0]  CFG_UNUSED     = 2'd3;

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic [ired_pkg::SAMPLE_BITS-1:0] sample_value;
  logic sample_present;
  logic frame_start;
  logic out_valid;
  logic out_stall;
  logic [ired_pkg::SAMPLE_BITS-1:0] result_value;
  logic result_present;
  logic row_end;
  logic cfg_valid;
  logic cfg_ready;
  logic [1:0] cfg_index;
  logic [12:0] cfg_data;

  int mismatch_count;
  int blocks_pending;
  int results_checked;

  // Stimulus shaping shared with the result sink
  bit tx_idle;
  bit rx_idle_allowed = 1'b1;
  bit holdoff_request = 1'b0;
  int words_sent = 0;
  int phases = 0;
  logic [12:0] cur_width = 13'd2;
  logic [2:0]  cur_chans = 3'd1;
  int stall_cycles = 0;

  always #5 clk = ~clk;

  image_two_by_two_reducer uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .sample_value(sample_value), .sample_present(sample_present),
    .frame_start(frame_start),
    .out_valid(out_valid), .out_stall(out_stall),
    .result_value(result_value), .result_present(result_present), .row_end(row_end),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  image_two_by_two_reducer_checker block_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .sample_value(sample_value), .sample_present(sample_present),
    .frame_start(frame_start),
    .out_valid(out_valid), .out_stall(out_stall),
    .result_value(result_value), .result_present(result_present), .row_end(row_end),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatch_count(mismatch_count), .blocks_pending(blocks_pending),
    .results_checked(results_checked)
  );

  // Watchdog: cycles without any accepted word
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Result sink: random stalls per word, bursts without stalls, long hold-off
  initial begin : result_sink
    int unsigned wait_cycles;
    int unsigned taken;
    bit rx_idle;
    out_stall = 1'b0;
    taken = 0;
    rx_idle = 1'b1;
    @(negedge clk);
    forever begin
      if (taken % 32 == 0) rx_idle = rx_idle_allowed && ($urandom_range(0, 3) != 0);
      wait_cycles = rx_idle ? $urandom_range(0, 15) : 0;
      if (wait_cycles != 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(negedge clk);
      end
      if (holdoff_request) begin
        out_stall <= 1'b1;
        repeat (HOLDOFF_CYCLES) @(negedge clk);
        holdoff_request = 1'b0;
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      taken++;
      @(negedge clk);
    end
  end

  // All stimulus tasks start and end at a falling edge.
  // send_word leaves in_valid high; the next call or settle takes it over.
  task automatic send_word(input logic [15:0] v, input logic p, input logic fs);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(0, 15) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       <= 1'b1;
    sample_value   <= v;
    sample_present <= p;
    frame_start    <= fs;
    do @(posedge clk); while (in_stall);
    words_sent++;
    @(negedge clk);
  endtask

  // Stop sending, wait for every expected word and for in-flight words to retire
  task automatic settle();
    in_valid <= 1'b0;
    while (blocks_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    phases++;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [12:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mode and channel words carry random upper bits
  task automatic write_config(input logic [2:0] mode, input logic [12:0] width,
                              input logic [2:0] chans);
    write_reg(ired_pkg::CFG_MODE, {10'($urandom), mode});
    write_reg(ired_pkg::CFG_WIDTH, width);
    write_reg(ired_pkg::CFG_CHANNELS, {10'($urandom), chans});
    cur_width = width;
    cur_chans = chans;
  endtask

  function automatic logic [16:0] rand_entry();
    logic [15:0] v;
    logic p;
    case ($urandom_range(0, 9))
      0:       v = 16'h0000;
      1:       v = 16'hFFFF;
      default: v = 16'($urandom);
    endcase
    p = ($urandom_range(0, 4) != 0);
    return {p, v};
  endfunction

  task automatic send_random_words(input int unsigned n, input bit fs_first);
    logic [16:0] s;
    for (int unsigned i = 0; i < n; i++) begin
      s = rand_entry();
      send_word(s[15:0], s[16], fs_first && (i == 0));
    end
  endtask

  // One block at width 2, one channel; entries are {present, value}
  task automatic send_quad(input logic [16:0] tl, input logic [16:0] tr,
                           input logic [16:0] bl, input logic [16:0] br);
    send_word(tl[15:0], tl[16], 1'b1);
    send_word(tr[15:0], tr[16], 1'b0);
    send_word(bl[15:0], bl[16], 1'b0);
    send_word(br[15:0], br[16], 1'b0);
  endtask

  initial begin : stimulus
    int rnd_start;
    int rnd_phase;
    int budget;
    int unsigned ew;
    int unsigned ec;
    int unsigned total;
    int unsigned restart_at;
    int unsigned stop_at;
    int unsigned row_pairs;
    logic [2:0] mode;
    logic [12:0] width;
    logic [2:0] chans;
    logic [16:0] s;
    bit noisy;

    rst            = 1'b1;
    in_valid       = 1'b0;
    sample_value   = '0;
    sample_present = 1'b0;
    frame_start    = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = ired_pkg::CFG_MODE;
    cfg_data       = '0;
    tx_idle        = 1'b1;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: reset settings (mean, width 2, one channel), full-scale sum
    send_quad(17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF);
    // First mode with an absent top-left sample
    settle();
    write_reg(ired_pkg::CFG_MODE, {10'd0, ired_pkg::MODE_FIRST});
    send_quad(17'h01234, 17'h1FFFF, 17'h10000, 17'h15555);
    // Mean of three present samples near full scale
    settle();
    write_reg(ired_pkg::CFG_MODE, {10'd0, ired_pkg::MODE_MEANP});
    send_quad(17'h1FFFF, 17'h1FFFE, 17'h0ABCD, 17'h1FFFD);
    // Minimum and maximum ignore absent samples
    settle();
    write_reg(ired_pkg::CFG_MODE, {10'd0, ired_pkg::MODE_MIN});
    send_quad(17'h18000, 17'h00000, 17'h10001, 17'h1FFFF);
    settle();
    write_reg(ired_pkg::CFG_MODE, {10'd0, ired_pkg::MODE_MAX});
    send_quad(17'h0FFFF, 17'h10000, 17'h17FFF, 17'h0FFFF);
    // Undefined mode gives an absent result
    settle();
    write_reg(ired_pkg::CFG_MODE, {10'h3FF, MODE_UNDEF});
    send_quad(17'h1AAAA, 17'h15555, 17'h1FFFF, 17'h10000);

    // Width shrinks mid-frame while the even row is past the new bound
    settle();
    write_config(ired_pkg::MODE_MEANP, 13'd8, 3'd2);
    send_random_words(12, 1'b1);
    settle();
    write_reg(ired_pkg::CFG_WIDTH, 13'd4);
    cur_width = 13'd4;
    send_random_words(26, 1'b0);

    // Write to an index with no register behind it
    settle();
    write_reg(CFG_UNUSED, 13'(($urandom)));

    // Random frames under random settings
    rnd_start = words_sent;
    rnd_phase = 0;
    while (words_sent - rnd_start < RANDOM_WORDS) begin
      rnd_phase++;
      settle();
      mode = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
      case ($urandom_range(0, 9))
        0:       width = 13'($urandom_range(0, 1));
        1:       width = 13'(2 * $urandom_range(1, 7) + 1);
        2:       width = 13'($urandom_range(17, 64));
        default: width = 13'(2 * $urandom_range(1, 8));
      endcase
      case ($urandom_range(0, 7))
        0:       chans = 3'd0;
        1:       chans = 3'($urandom_range(5, 7));
        default: chans = 3'($urandom_range(1, 4));
      endcase
      row_pairs = $urandom_range(1, 3);
      noisy = 1'b1;
      tx_idle = ($urandom_range(0, 3) != 0);
      // Long output hold-off while the sender keeps offering words
      if (rnd_phase == HOLDOFF_PHASE) begin
        width = 13'd16;
        chans = 3'd2;
        row_pairs = 3;
        noisy = 1'b0;
        tx_idle = 1'b0;
        holdoff_request = 1'b1;
      end
      write_config(mode, width, chans);

      ew = (cur_width < 2) ? 2 : ((cur_width > 4096) ? 4096 : cur_width);
      ec = (cur_chans < 1) ? 1 : ((cur_chans > 4) ? 4 : cur_chans);
      total = row_pairs * 2 * ew * ec;
      restart_at = total;
      stop_at = total;
      // Noise: restart mid-frame, or cut the frame short
      if (noisy && $urandom_range(0, 7) == 0) restart_at = $urandom_range(1, total - 1);
      if (noisy && $urandom_range(0, 7) == 0) stop_at = $urandom_range(1, total - 1);
      // Last frame is cut to keep the word count near its target
      budget = RANDOM_WORDS - (words_sent - rnd_start);
      if (int'(stop_at) > budget) stop_at = unsigned'(budget);
      for (int unsigned i = 0; i < stop_at; i++) begin
        s = rand_entry();
        send_word(s[15:0], s[16], (i == 0) || (i == restart_at));
      end
    end

    // Width above range is clamped; a partial even row gives no result
    settle();
    tx_idle = 1'b0;
    rx_idle_allowed = 1'b0;
    write_config(ired_pkg::MODE_MAX, 13'h1FFF, 3'd1);
    send_random_words(CLAMP_WORDS, 1'b1);

    // Drain and give the verdict
    settle();
    $display("Summary: %0d input words, %0d result words checked, %0d idle phases",
             words_sent, results_checked, phases);
    $display("Covered all combine modes, widths 0 to 8191, channel counts 0 to 7, %s",
             "missing samples, a mid-frame width change and a long output hold-off");
    if (mismatch_count == 0 && blocks_pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+rtl
rtl/ired_pkg.sv
rtl/ired_ctrl.sv
rtl/ired_datapath.sv
rtl/image_two_by_two_reducer.sv
tb/image_two_by_two_reducer_checker.sv
tb/tb_image_two_by_two_reducer.sv
